### rtl/core/tlap_pkg.sv
// Package for the two-level adaptive predictor: table geometry, mode and
// operation codes, automaton next-state and prediction functions.
// No dependencies.
`default_nettype none

package tlap_pkg;

  localparam int ADDR_W       = 64;
  localparam int HIST_ENTRIES = 256;
  localparam int SLOT_W       = $clog2(HIST_ENTRIES);
  localparam int TAG_W        = ADDR_W - SLOT_W;
  localparam int HIST_W       = 8;
  localparam int PAT_ENTRIES  = 1 << HIST_W;
  localparam int MODE_W       = 3;
  localparam int DATA_W       = 32;
  localparam int PADDR_W      = 3;

  typedef logic [MODE_W-1:0] mode_t;
  typedef logic [1:0]        pstate_t;

  localparam mode_t MODE_ALWAYS = 3'd0;
  localparam mode_t MODE_LAST   = 3'd1;
  localparam mode_t MODE_A1     = 3'd2;
  localparam mode_t MODE_A2     = 3'd3;
  localparam mode_t MODE_A3     = 3'd4;
  localparam mode_t MODE_A4     = 3'd5;
  localparam mode_t MODE_RESET  = MODE_A2;

  localparam logic OP_PREDICT = 1'b0;
  localparam logic OP_UPDATE  = 1'b1;

  localparam logic REG_MODE = 1'b0;

  function automatic pstate_t next_state(mode_t m, pstate_t st, logic t);
    pstate_t ns;
    ns = 2'd0;
    case (m)
      MODE_LAST: ns = {1'b0, t};
      MODE_A1:   ns = {st[0], t};
      MODE_A2: begin
        if (t) ns = (st == 2'd3) ? 2'd3 : st + 2'd1;
        else   ns = (st == 2'd0) ? 2'd0 : st - 2'd1;
      end
      MODE_A3: begin
        case (st)
          2'd0:    ns = t ? 2'd1 : 2'd0;
          2'd1:    ns = t ? 2'd3 : 2'd0;
          2'd2:    ns = t ? 2'd3 : 2'd0;
          default: ns = t ? 2'd3 : 2'd2;
        endcase
      end
      MODE_A4: begin
        case (st)
          2'd0:    ns = t ? 2'd1 : 2'd0;
          2'd1:    ns = t ? 2'd3 : 2'd0;
          2'd2:    ns = t ? 2'd3 : 2'd1;
          default: ns = t ? 2'd3 : 2'd2;
        endcase
      end
      default: ns = st;
    endcase
    return ns;
  endfunction

  function automatic logic predict(mode_t m, pstate_t st);
    logic p;
    case (m)
      MODE_ALWAYS: p = 1'b1;
      MODE_LAST:   p = (st != 2'd0);
      MODE_A1:     p = (st != 2'd0);
      MODE_A2:     p = st[1];
      MODE_A3:     p = st[1];
      MODE_A4:     p = st[1];
      default:     p = 1'b0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

### rtl/core/two_level_adaptive_predictor.sv
// Two-level adaptive predictor (per-address history, shared pattern table).
// Depends on tlap_pkg.
//
// Usage:
//   Input: present in_operation, in_address, in_taken with start; the item
//   is taken at a clock edge where start is high and busy is low.
//   Predict items give one result on out_prediction, marked by out_valid
//   for exactly one cycle; update items give none. The receiver cannot
//   stall; results are never held.
//   Steps: the accept edge reads the history/tag memory, S_HIST the
//   pattern memory at that history; S_PAT registers the result and writes.
//   busy is high in S_HIST and S_PAT, so no new item is taken before the
//   last is through. Config: APB-style, mode at byte address 0; the user
//   must write it only while idle. The block does not enforce this.
//   Reset (rst_n low, synchronous): mode returns to A2, all history and
//   pattern valid bits clear, so every entry reads as zero/invalid at once.
//   No clearing pass is needed.
`default_nettype none

module two_level_adaptive_predictor (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output      logic                        busy,
  input  wire logic                        in_operation,
  input  wire logic [tlap_pkg::ADDR_W-1:0] in_address,
  input  wire logic                        in_taken,
  output      logic                        out_valid,
  output      logic                        out_prediction,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tlap_pkg::PADDR_W-1:0] paddr,
  input  wire logic [tlap_pkg::DATA_W-1:0] pwdata,
  output      logic [tlap_pkg::DATA_W-1:0] prdata,
  output      logic                        pready
);
  import tlap_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_HIST, S_PAT} state_t;

  state_t                 state_r;
  mode_t                  mode_r;
  logic                   out_valid_r;
  logic                   out_pred_r;
  logic [HIST_ENTRIES-1:0] hvld_r;
  logic [PAT_ENTRIES-1:0]  pvld_r;

  logic                   op_r;
  logic                   taken_r;
  logic [ADDR_W-1:0]      addr_r;
  logic                   hit_r;
  logic [HIST_W-1:0]      hist_r;

  logic [TAG_W+HIST_W-1:0] ht_mem [HIST_ENTRIES];
  logic [TAG_W+HIST_W-1:0] ht_q;
  pstate_t                 pat_mem [PAT_ENTRIES];
  pstate_t                 pat_q;

  logic                   accept;
  logic                   act;
  logic [SLOT_W-1:0]      slot;
  logic [TAG_W-1:0]       tag;
  logic                   hit;
  logic [HIST_W-1:0]      hist_sel;
  pstate_t                st;
  pstate_t                st_nxt;
  logic [HIST_W-1:0]      hist_nxt;
  logic                   ht_we;
  logic [TAG_W+HIST_W-1:0] ht_wdata;
  logic                   pat_we;
  logic                   cfg_wr;

  assign accept  = start && !busy;
  assign busy    = (state_r != S_IDLE);
  assign act     = (mode_r == MODE_LAST) || (mode_r == MODE_A1) || (mode_r == MODE_A2) ||
                   (mode_r == MODE_A3) || (mode_r == MODE_A4);
  assign slot    = addr_r[SLOT_W-1:0];
  assign tag     = addr_r[ADDR_W-1:SLOT_W];
  assign hit     = hvld_r[slot] && (ht_q[TAG_W+HIST_W-1:HIST_W] == tag);
  assign hist_sel = hit ? ht_q[HIST_W-1:0] : '0;
  assign st      = pvld_r[hist_r] ? pat_q : 2'd0;
  assign st_nxt  = next_state(mode_r, st, taken_r);
  assign hist_nxt = HIST_W'({hist_r, taken_r});

  assign ht_we    = (state_r == S_PAT) && act && ((op_r == OP_UPDATE) || !hit_r);
  assign ht_wdata = {tag, (op_r == OP_UPDATE) ? hist_nxt : {HIST_W{1'b0}}};
  assign pat_we   = (state_r == S_PAT) && act && (op_r == OP_UPDATE);

  assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == REG_MODE);
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_MODE) ? DATA_W'(mode_r) : '0;

  assign out_valid      = out_valid_r;
  assign out_prediction = out_pred_r;

  // memories
  always_ff @(posedge clk) begin
    if (accept) begin
      ht_q <= ht_mem[in_address[SLOT_W-1:0]];
    end
    if (ht_we) begin
      ht_mem[slot] <= ht_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_HIST) begin
      pat_q <= pat_mem[hist_sel];
    end
    if (pat_we) begin
      pat_mem[hist_r] <= st_nxt;
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_operation;
      taken_r <= in_taken;
      addr_r  <= in_address;
    end
    if (state_r == S_HIST) begin
      hit_r  <= hit;
      hist_r <= hist_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_RESET;
      out_valid_r <= 1'b0;
      hvld_r      <= '0;
      pvld_r      <= '0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_wr) begin
        mode_r <= pwdata[MODE_W-1:0];
      end
      case (state_r)
        S_IDLE: begin
          if (start) state_r <= S_HIST;
        end
        S_HIST: state_r <= S_PAT;
        S_PAT: begin
          state_r     <= S_IDLE;
          out_valid_r <= (op_r == OP_PREDICT);
          out_pred_r  <= predict(mode_r, st);
          if (ht_we)  hvld_r[slot]   <= 1'b1;
          if (pat_we) pvld_r[hist_r] <= 1'b1;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_result_after_pat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == S_PAT) && (op_r == OP_PREDICT))
    else $error("result strobe outside predict completion");

  a_hist_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HIST) |-> $past(start && !busy))
    else $error("lookup started without an accepted item");

  a_no_update_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PAT) && (op_r == OP_UPDATE) |=> !out_valid)
    else $error("update produced a result");

  a_pat_write_update: assert property (@(posedge clk) disable iff (!rst_n)
    pat_we |-> act && (op_r == OP_UPDATE) && (state_r == S_PAT))
    else $error("pattern write outside an update");

endmodule

`default_nettype wire

### bench/tb_two_level_adaptive_predictor.sv
`timescale 1ns / 100ps
// Testbench for two_level_adaptive_predictor: predict and update items in every
// mode, predicted in a small scoreboard class and checked result by result.
// Depends on tlap_pkg and the two_level_adaptive_predictor RTL.

module tb_two_level_adaptive_predictor;
  import tlap_pkg::*;

  localparam int IDLE_LIMIT = 400;
  localparam logic [PADDR_W-1:0] MODE_ADDR  = PADDR_W'(4 * REG_MODE);
  localparam logic [PADDR_W-1:0] SPARE_ADDR = PADDR_W'(4);
  localparam mode_t MODE_SPARE6 = 3'd6;
  localparam mode_t MODE_SPARE7 = 3'd7;

  class prediction_tracker;
    mode_t             cur_mode;
    logic [HIST_W-1:0] hist_mem [HIST_ENTRIES];
    logic [TAG_W-1:0]  tag_mem [HIST_ENTRIES];
    bit                line_valid [HIST_ENTRIES];
    pstate_t           pattern_mem [PAT_ENTRIES];
    pstate_t           step_tab [4][4][2];
    bit                due_predictions [$];
    int                mismatches;

    function new();
      cur_mode = MODE_RESET;
      foreach (hist_mem[i]) begin
        hist_mem[i]   = '0;
        tag_mem[i]    = '0;
        line_valid[i] = 1'b0;
      end
      foreach (pattern_mem[i]) pattern_mem[i] = '0;
      // A1, A2, A3, A4: [state][outcome]
      step_tab = '{'{'{2'd0, 2'd1}, '{2'd2, 2'd3}, '{2'd0, 2'd1}, '{2'd2, 2'd3}},
                   '{'{2'd0, 2'd1}, '{2'd0, 2'd2}, '{2'd1, 2'd3}, '{2'd2, 2'd3}},
                   '{'{2'd0, 2'd1}, '{2'd0, 2'd3}, '{2'd0, 2'd3}, '{2'd2, 2'd3}},
                   '{'{2'd0, 2'd1}, '{2'd0, 2'd3}, '{2'd1, 2'd3}, '{2'd2, 2'd3}}};
      mismatches = 0;
    endfunction

    function void apply_cfg(logic [PADDR_W-1:0] a, logic [DATA_W-1:0] d);
      if (a == MODE_ADDR) cur_mode = d[MODE_W-1:0];
    endfunction

    // tag miss takes the slot over with zero history
    function int unsigned claim_slot(logic [ADDR_W-1:0] a);
      int unsigned s;
      logic [TAG_W-1:0] t;
      s = 32'(a[SLOT_W-1:0]);
      t = a[ADDR_W-1:SLOT_W];
      if (!line_valid[s] || tag_mem[s] != t) begin
        tag_mem[s]    = t;
        line_valid[s] = 1'b1;
        hist_mem[s]   = '0;
      end
      return s;
    endfunction

    function void note_item(logic op, logic [ADDR_W-1:0] a, logic tk);
      int unsigned s;
      logic [HIST_W-1:0] h;
      pstate_t st;
      if (cur_mode == MODE_ALWAYS || cur_mode > MODE_A4) begin
        if (op == OP_PREDICT) due_predictions.push_back(cur_mode == MODE_ALWAYS);
        return;
      end
      s  = claim_slot(a);
      h  = hist_mem[s];
      st = pattern_mem[h];
      if (op == OP_PREDICT) begin
        due_predictions.push_back((cur_mode <= MODE_A1) ? (st != 2'd0) : st[1]);
      end else begin
        hist_mem[s] = {h[HIST_W-2:0], tk};
        if (cur_mode == MODE_LAST) pattern_mem[h] = {1'b0, tk};
        else pattern_mem[h] = step_tab[cur_mode - MODE_A1][st][tk];
      end
    endfunction

    function void check_prediction(logic got);
      bit want;
      if (due_predictions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected prediction %0b at %0t", got, $time);
        return;
      end
      want = due_predictions.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("prediction mismatch: expected %0b, got %0b at %0t", want, got, $time);
      end
    endfunction

    function int pending();
      return due_predictions.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic in_operation;
  logic [ADDR_W-1:0] in_address;
  logic in_taken;
  logic out_valid;
  logic out_prediction;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  prediction_tracker tracker;
  int run_free;
  int idle_cycles;
  logic [ADDR_W-1:0] addr_pool [12];

  two_level_adaptive_predictor DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_operation(in_operation),
    .in_address(in_address),
    .in_taken(in_taken),
    .out_valid(out_valid),
    .out_prediction(out_prediction),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) tracker.check_prediction(out_prediction);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  task send_item(logic op, logic [ADDR_W-1:0] a, logic tk);
    int gap;
    gap = (run_free > 0) ? 0 : pick_gap();
    if (run_free > 0) run_free--;
    else if ($urandom_range(0, 39) == 0) run_free = $urandom_range(20, 60);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_operation <= op;
    in_address   <= a;
    in_taken     <= tk;
    do @(posedge clk); while (busy);
    tracker.note_item(op, a, tk);
  endtask

  // only while idle; updates give no result, so allow their latency too
  task cfg_write(logic [PADDR_W-1:0] a, logic [DATA_W-1:0] d);
    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.apply_cfg(a, d);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // few slots, few tags: slots are shared and retaken often
  task fill_pool();
    logic [TAG_W-1:0]  tags [3];
    logic [SLOT_W-1:0] slots [4];
    foreach (tags[i]) tags[i] = TAG_W'({$urandom, $urandom});
    foreach (slots[i]) slots[i] = SLOT_W'($urandom);
    foreach (addr_pool[i])
      addr_pool[i] = {tags[$urandom_range(0, 2)], slots[$urandom_range(0, 3)]};
  endtask

  task random_items(int n);
    int r;
    logic op;
    logic tk;
    logic [ADDR_W-1:0] a;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        a  = addr_pool[$urandom_range(0, 11)];
        op = ($urandom_range(0, 9) < 6) ? OP_UPDATE : OP_PREDICT;
        tk = ($urandom_range(0, 9) < (a[0] ? 8 : 3));
      end else begin
        if (r < 90) begin
          a = {$urandom, $urandom};
        end else begin
          case ($urandom_range(0, 3))
            0: a = '0;
            1: a = '1;
            2: a = {{TAG_W{1'b1}}, {SLOT_W{1'b0}}};
            default: a = {{TAG_W{1'b0}}, {SLOT_W{1'b1}}};
          endcase
        end
        op = 1'($urandom_range(0, 1));
        tk = 1'($urandom_range(0, 1));
      end
      send_item(op, a, tk);
    end
  endtask

  task run_phase(mode_t m, int n);
    logic [DATA_W-1:0] d;
    d = $urandom;
    d[MODE_W-1:0] = m;
    if ($urandom_range(0, 1)) cfg_write(SPARE_ADDR, $urandom);
    cfg_write(MODE_ADDR, d);
    fill_pool();
    random_items(n);
  endtask

  initial begin
    mode_t order [8];
    order = '{MODE_LAST, MODE_A4, MODE_A1, MODE_A3, MODE_ALWAYS, MODE_A2,
              MODE_SPARE7, MODE_SPARE6};
    tracker      = new();
    run_free     = 0;
    idle_cycles  = 0;
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_operation <= OP_PREDICT;
    in_address   <= '0;
    in_taken     <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset mode A2: misses, history build-up, slot taken over by a new tag
    send_item(OP_PREDICT, '0, 1'b1);
    send_item(OP_UPDATE, '0, 1'b1);
    send_item(OP_UPDATE, '0, 1'b1);
    send_item(OP_UPDATE, '0, 1'b1);
    send_item(OP_PREDICT, '0, 1'b0);
    send_item(OP_UPDATE, '1, 1'b0);
    send_item(OP_UPDATE, '1, 1'b1);
    send_item(OP_PREDICT, '1, 1'b1);
    send_item(OP_UPDATE, {{(TAG_W-1){1'b0}}, 1'b1, {SLOT_W{1'b0}}}, 1'b1);
    send_item(OP_PREDICT, '0, 1'b0);
    send_item(OP_UPDATE, '0, 1'b1);
    send_item(OP_PREDICT, '0, 1'b0);
    // always true, with upper data bits masked off
    cfg_write(MODE_ADDR, {{(DATA_W-MODE_W){1'b1}}, MODE_ALWAYS});
    send_item(OP_PREDICT, '1, 1'b0);
    send_item(OP_UPDATE, '1, 1'b1);
    cfg_write(SPARE_ADDR, DATA_W'(MODE_A3));
    send_item(OP_PREDICT, '0, 1'b0);
    // unused modes
    cfg_write(MODE_ADDR, DATA_W'(MODE_SPARE6));
    send_item(OP_PREDICT, '0, 1'b1);
    send_item(OP_UPDATE, '0, 1'b1);
    cfg_write(MODE_ADDR, {{(DATA_W-MODE_W){1'b0}}, MODE_SPARE7});
    send_item(OP_PREDICT, '1, 1'b0);
    // last-time over states left by A2
    cfg_write(MODE_ADDR, DATA_W'(MODE_LAST));
    send_item(OP_UPDATE, '0, 1'b0);
    send_item(OP_UPDATE, '0, 1'b1);
    send_item(OP_PREDICT, '0, 1'b0);

    foreach (order[i])
      run_phase(order[i], (order[i] == MODE_ALWAYS || order[i] > MODE_A4) ? 50 : 150);
    for (int p = 0; p < 6; p++)
      run_phase(mode_t'($urandom_range(MODE_LAST, MODE_A4)), 140);

    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/tlap_pkg.sv
rtl/core/two_level_adaptive_predictor.sv
bench/tb_two_level_adaptive_predictor.sv
